>>> design/kpi_pkg.sv
`default_nettype none
package kpi_pkg;

	localparam int MAX_FRAMES = 256;
	localparam int CHANNELS   = 16;
	localparam int FW         = $clog2(MAX_FRAMES);
	localparam int CW         = $clog2(CHANNELS);
	localparam int FCW        = FW + 1;
	localparam int SPW        = 15;
	localparam int TW         = 31;

	localparam logic [SPW-1:0] SPEED_MIN = 15'd3;
	localparam logic [SPW-1:0] SPEED_MAX = 15'd25600;
	localparam logic [SPW-1:0] SPEED_RST = 15'd256;

	localparam logic [3:0] OP_TICK       = 4'd0;
	localparam logic [3:0] OP_PLAY       = 4'd1;
	localparam logic [3:0] OP_PAUSE      = 4'd2;
	localparam logic [3:0] OP_STOP       = 4'd3;
	localparam logic [3:0] OP_STEP_FWD   = 4'd4;
	localparam logic [3:0] OP_STEP_BACK  = 4'd5;
	localparam logic [3:0] OP_SEEK_FRAME = 4'd6;
	localparam logic [3:0] OP_SEEK_TIME  = 4'd7;
	localparam logic [3:0] OP_SEEK_DELTA = 4'd8;
	localparam logic [3:0] OP_LOAD_TIME  = 4'd9;
	localparam logic [3:0] OP_LOAD_VALUE = 4'd10;
	localparam logic [3:0] OP_READ       = 4'd11;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NO_FRAMES = 2'd1;
	localparam logic [1:0] ST_RANGE     = 2'd2;
	localparam logic [1:0] ST_AT_END    = 2'd3;

	localparam logic [1:0] REG_FRAME_COUNT = 2'd0;
	localparam logic [1:0] REG_SPEED       = 2'd1;
	localparam logic [1:0] REG_LOOP        = 2'd2;
	localparam logic [1:0] REG_INTERP      = 2'd3;

	typedef enum logic [4:0] {
		S_IDLE, S_TOT_RD, S_TOT_CK, S_ADVANCE, S_MOD, S_SRCH_RD, S_SRCH_CK,
		S_IP_GO, S_IP_RD0, S_IP_CK0, S_IP_RD1, S_IP_CK1, S_FRAC,
		S_CH_RDA, S_CH_RDB, S_CH_MUL, S_CH_ADD, S_EMIT, S_REL_RD, S_REL_CK, S_DONE
	} kpi_state_t;

	typedef struct packed {
		logic [3:0]         req_type;
		logic [15:0]        dt;
		logic [7:0]         frame_index;
		logic [3:0]         channel;
		logic signed [31:0] value;
		logic signed [31:0] time_arg;
	} kpi_req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [7:0]         current_frame;
		logic [30:0]        play_time;
		logic               playing;
		logic               frame_changed;
		logic [3:0]         out_channel;
		logic signed [31:0] sample_value;
		logic               last;
	} kpi_rsp_t;

	function automatic logic [TW-1:0] rel_time(input logic [31:0] ts, input logic [31:0] ts0);
		logic signed [32:0] d;
		d = $signed({ts[31], ts}) - $signed({ts0[31], ts0});
		if (d[32])
			return '0;
		else if (d[31])
			return '1;
		return d[30:0];
	endfunction

endpackage
`default_nettype wire

>>> design/kpi_req_if.sv
`default_nettype none
interface kpi_req_if;
	import kpi_pkg::*;
	logic     valid;
	logic     ready;
	kpi_req_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

>>> design/kpi_rsp_if.sv
`default_nettype none
interface kpi_rsp_if;
	import kpi_pkg::*;
	logic     valid;
	logic     ready;
	kpi_rsp_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

>>> design/kpi_cfg_if.sv
`default_nettype none
interface kpi_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  wr_index;
	logic [14:0] wr_data;
	modport source(output valid, output wr_index, output wr_data, input ready);
	modport sink(input valid, input wr_index, input wr_data, output ready);
endinterface
`default_nettype wire

>>> design/keyframe_playback_interpolator.sv
`default_nettype none
// Keyframe player: frames are loaded one word per transaction into a 256-entry
// timestamp RAM and a 4096-entry sample RAM, and play, pause, stop, step, seek,
// tick and read requests move a playback clock over them. One request is in
// flight at a time and req.ready is low until its last result has been handed
// to the output register. Time seeks run a binary search over the timestamp
// RAM, a read state and a compare state per probe on its one read port. A tick
// runs the search, a wrap modulo when it wraps and an interpolation fraction,
// the last two on one shared restoring divider, and then for each channel reads
// two samples, multiplies and adds when it interpolates, and hands the result
// off; a read takes the two sample reads and the hand-off for each channel.
// No clearing pass after reset.
module keyframe_playback_interpolator (
	input  wire clk,
	input  wire arst_n,
	kpi_cfg_if.sink   cfg,
	kpi_req_if.sink   req,
	kpi_rsp_if.source rsp
);
	import kpi_pkg::*;

	kpi_state_t state_q, state_d;

	logic [3:0]         op_q;
	logic [15:0]        dt_q;
	logic signed [32:0] tgt_q;
	logic [FW-1:0]      fp_q, prev_q, idx_q;
	logic [TW-1:0]      tp_q, tot_q, t0r_q;
	logic               play_q, loop_q, interp_q;
	logic [FCW-1:0]     fc_q, lo_q, hi_q;
	logic [SPW-1:0]     spd_q;
	logic [31:0]        t0_q;
	logic [30:0]        dtsp_q;
	logic [23:0]        step_q;
	logic [31:0]        d_q;
	logic [32:0]        div_r_q;
	logic [31:0]        div_q_q;
	logic [TW-1:0]      div_d_q;
	logic [5:0]         cnt_q;
	logic               use_frac_q, changed_q;
	logic [CW-1:0]      c_q;
	logic signed [31:0] a_q, smp_q;
	logic signed [49:0] prod_q;
	logic [1:0]         status_q;
	logic               rsp_valid_q;
	kpi_rsp_t           rsp_q;

	logic [31:0]          tdata, vdata;
	logic [FW-1:0]        t_raddr;
	logic [FW+CW-1:0]     v_raddr;
	logic                 none, rsp_free, accept;
	logic [FCW-1:0]       mid, fp_inc, fcm1;
	logic [TW-1:0]        rel_t;
	logic [31:0]          t_adv;
	logic [32:0]          div_sh, div_r_n;
	logic                 div_ge;
	logic [31:0]          div_q_n;
	logic signed [49:0]   lerp_sum;
	logic [FCW-1:0]       fc_new;
	logic [SPW-1:0]       spd_new;

	assign none     = (fc_q == '0);
	assign rsp_free = !rsp_valid_q || rsp.ready;
	assign accept   = (state_q == S_IDLE) && req.valid;
	assign mid      = lo_q + ((hi_q - lo_q) >> 1);
	assign fp_inc   = {1'b0, fp_q} + FCW'(1);
	assign fcm1     = fc_q - FCW'(1);
	assign rel_t    = rel_time(tdata, t0_q);
	assign t_adv    = {1'b0, tp_q} + {8'b0, step_q};
	assign div_sh   = {div_r_q[31:0], div_q_q[31]};
	assign div_ge   = div_sh >= {2'b00, div_d_q};
	assign div_r_n  = div_ge ? div_sh - {2'b00, div_d_q} : div_sh;
	assign div_q_n  = {div_q_q[30:0], div_ge};
	assign lerp_sum = prod_q + 50'sd32768;

	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	always_comb begin
		fc_new = (cfg.wr_data[FCW-1:0] > FCW'(MAX_FRAMES)) ? FCW'(MAX_FRAMES)
			: cfg.wr_data[FCW-1:0];
		if (cfg.wr_data < SPEED_MIN)
			spd_new = SPEED_MIN;
		else if (cfg.wr_data > SPEED_MAX)
			spd_new = SPEED_MAX;
		else
			spd_new = cfg.wr_data;
	end

	kpi_ram #(.WIDTH(32), .DEPTH(MAX_FRAMES)) u_time_ram (
		.clk   (clk),
		.we    (accept && req.data.req_type == OP_LOAD_TIME),
		.waddr (req.data.frame_index),
		.wdata (req.data.time_arg),
		.raddr (t_raddr),
		.rdata (tdata)
	);

	kpi_ram #(.WIDTH(32), .DEPTH(MAX_FRAMES * CHANNELS)) u_value_ram (
		.clk   (clk),
		.we    (accept && req.data.req_type == OP_LOAD_VALUE),
		.waddr ({req.data.frame_index, req.data.channel}),
		.wdata (req.data.value),
		.raddr (v_raddr),
		.rdata (vdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		t_raddr = fp_q;
		v_raddr = {fp_q, c_q};
		unique case (state_q)
			S_IDLE: if (req.valid) begin
				unique case (req.data.req_type)
					OP_TICK, OP_SEEK_TIME, OP_SEEK_DELTA:
						state_d = none ? S_DONE : S_TOT_RD;
					OP_STEP_FWD:
						state_d = (!none && fp_inc < fc_q) ? S_REL_RD : S_DONE;
					OP_STEP_BACK:
						state_d = (!none && (fp_q != '0 || loop_q)) ? S_REL_RD : S_DONE;
					OP_SEEK_FRAME:
						state_d = (!none && {1'b0, req.data.frame_index} < fc_q)
							? S_REL_RD : S_DONE;
					OP_READ:
						state_d = none ? S_DONE : S_CH_RDA;
					default:
						state_d = S_DONE;
				endcase
			end
			S_TOT_RD: begin
				t_raddr = fcm1[FW-1:0];
				state_d = S_TOT_CK;
			end
			S_TOT_CK: state_d = S_ADVANCE;
			S_ADVANCE: begin
				if (op_q == OP_TICK) begin
					if (play_q && tot_q != '0)
						state_d = (t_adv >= {1'b0, tot_q} && loop_q) ? S_MOD : S_SRCH_RD;
					else
						state_d = S_IP_GO;
				end else if (tgt_q[32] || tgt_q == '0 || tgt_q >= $signed({2'b00, tot_q}))
					state_d = S_DONE;
				else
					state_d = S_SRCH_RD;
			end
			S_MOD: if (cnt_q == '0)
				state_d = S_SRCH_RD;
			S_SRCH_RD: begin
				t_raddr = mid[FW-1:0];
				if (lo_q < hi_q)
					state_d = S_SRCH_CK;
				else
					state_d = (op_q == OP_TICK) ? S_IP_GO : S_DONE;
			end
			S_SRCH_CK: state_d = S_SRCH_RD;
			S_IP_GO: state_d = (interp_q && fp_inc < fc_q) ? S_IP_RD0 : S_CH_RDA;
			S_IP_RD0: state_d = S_IP_CK0;
			S_IP_CK0: state_d = S_IP_RD1;
			S_IP_RD1: begin
				t_raddr = fp_inc[FW-1:0];
				state_d = S_IP_CK1;
			end
			S_IP_CK1: state_d = (tp_q > t0r_q && tp_q < rel_t) ? S_FRAC : S_CH_RDA;
			S_FRAC: if (cnt_q == '0)
				state_d = S_CH_RDA;
			S_CH_RDA: state_d = S_CH_RDB;
			S_CH_RDB: begin
				v_raddr = {fp_inc[FW-1:0], c_q};
				state_d = use_frac_q ? S_CH_MUL : S_EMIT;
			end
			S_CH_MUL: state_d = S_CH_ADD;
			S_CH_ADD: state_d = S_EMIT;
			S_EMIT: if (rsp_free)
				state_d = (c_q == CW'(CHANNELS - 1)) ? S_IDLE : S_CH_RDA;
			S_REL_RD: begin
				t_raddr = idx_q;
				state_d = S_REL_CK;
			end
			S_REL_CK: state_d = S_DONE;
			S_DONE: if (rsp_free)
				state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fp_q        <= '0;
			tp_q        <= '0;
			play_q      <= 1'b0;
			fc_q        <= '0;
			spd_q       <= SPEED_RST;
			loop_q      <= 1'b1;
			interp_q    <= 1'b1;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp.ready)
				rsp_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (req.valid) begin
					unique case (req.data.req_type)
						OP_PLAY: if (!none) begin
							if ({1'b0, fp_q} >= fcm1) begin
								fp_q <= '0;
								tp_q <= '0;
							end
							play_q <= 1'b1;
						end
						OP_PAUSE: play_q <= 1'b0;
						OP_STOP: begin
							play_q <= 1'b0;
							fp_q   <= '0;
							tp_q   <= '0;
						end
						OP_STEP_FWD: if (!none) begin
							if (fp_inc < fc_q)
								fp_q <= fp_inc[FW-1:0];
							else if (loop_q) begin
								fp_q <= '0;
								tp_q <= '0;
							end
						end
						OP_STEP_BACK: if (!none) begin
							if (fp_q != '0)
								fp_q <= fp_q - FW'(1);
							else if (loop_q)
								fp_q <= fcm1[FW-1:0];
						end
						OP_SEEK_FRAME: if (!none && {1'b0, req.data.frame_index} < fc_q)
							fp_q <= req.data.frame_index;
						default: ;
					endcase
				end
				S_ADVANCE: begin
					if (op_q == OP_TICK) begin
						if (play_q && tot_q != '0) begin
							if (t_adv >= {1'b0, tot_q}) begin
								if (!loop_q) begin
									tp_q   <= tot_q;
									play_q <= 1'b0;
								end
							end else
								tp_q <= t_adv[TW-1:0];
						end
					end else if (tgt_q[32] || tgt_q == '0) begin
						fp_q <= '0;
						tp_q <= '0;
					end else if (tgt_q >= $signed({2'b00, tot_q})) begin
						fp_q <= fcm1[FW-1:0];
						tp_q <= tot_q;
					end else
						tp_q <= tgt_q[TW-1:0];
				end
				S_MOD: if (cnt_q == '0)
					tp_q <= div_r_q[TW-1:0];
				S_SRCH_RD: if (lo_q >= hi_q)
					fp_q <= (lo_q == '0) ? '0 : FW'(lo_q - FCW'(1));
				S_EMIT: if (rsp_free)
					rsp_valid_q <= 1'b1;
				S_REL_CK: tp_q <= rel_t;
				S_DONE: if (rsp_free)
					rsp_valid_q <= 1'b1;
				default: ;
			endcase
			if (cfg.valid) begin
				unique case (cfg.wr_index)
					REG_FRAME_COUNT: begin
						fc_q <= fc_new;
						if (fc_new == '0)
							fp_q <= '0;
						else if ({1'b0, fp_q} >= fc_new)
							fp_q <= FW'(fc_new - FCW'(1));
					end
					REG_SPEED:  spd_q    <= spd_new;
					REG_LOOP:   loop_q   <= cfg.wr_data[0];
					REG_INTERP: interp_q <= cfg.wr_data[0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: if (req.valid) begin
				op_q       <= req.data.req_type;
				dt_q       <= req.data.dt;
				prev_q     <= fp_q;
				status_q   <= ST_OK;
				changed_q  <= 1'b0;
				use_frac_q <= 1'b0;
				c_q        <= '0;
				if (req.data.req_type == OP_SEEK_DELTA)
					tgt_q <= $signed({2'b00, tp_q}) + $signed({req.data.time_arg[31],
						req.data.time_arg});
				else
					tgt_q <= $signed({req.data.time_arg[31], req.data.time_arg});
				unique case (req.data.req_type)
					OP_TICK, OP_PLAY, OP_SEEK_TIME, OP_SEEK_DELTA, OP_READ:
						if (none) status_q <= ST_NO_FRAMES;
					OP_STEP_FWD: begin
						idx_q <= fp_inc[FW-1:0];
						if (none)
							status_q <= ST_NO_FRAMES;
						else if (fp_inc >= fc_q && !loop_q)
							status_q <= ST_AT_END;
					end
					OP_STEP_BACK: begin
						idx_q <= (fp_q != '0) ? fp_q - FW'(1) : fcm1[FW-1:0];
						if (none)
							status_q <= ST_NO_FRAMES;
						else if (fp_q == '0 && !loop_q)
							status_q <= ST_AT_END;
					end
					OP_SEEK_FRAME: begin
						idx_q <= req.data.frame_index;
						if (none)
							status_q <= ST_NO_FRAMES;
						else if ({1'b0, req.data.frame_index} >= fc_q)
							status_q <= ST_RANGE;
					end
					OP_LOAD_TIME: if (req.data.frame_index == '0)
						t0_q <= req.data.time_arg;
					default: ;
				endcase
			end
			S_TOT_RD: dtsp_q <= 31'(dt_q * spd_q);
			S_TOT_CK: begin
				tot_q  <= rel_t;
				step_q <= 24'((32'(dtsp_q) + 32'd128) >> 8);
			end
			S_ADVANCE: begin
				lo_q    <= '0;
				hi_q    <= fc_q;
				div_r_q <= '0;
				div_q_q <= t_adv;
				div_d_q <= tot_q;
				cnt_q   <= 6'd32;
			end
			S_MOD: if (cnt_q != '0) begin
				div_r_q <= div_r_n;
				div_q_q <= div_q_n;
				cnt_q   <= cnt_q - 6'd1;
			end
			S_SRCH_CK: begin
				if ({1'b0, tp_q} < {1'b0, rel_t})
					hi_q <= mid;
				else
					lo_q <= mid + FCW'(1);
			end
			S_IP_GO: changed_q <= (fp_q != prev_q);
			S_IP_CK0: t0r_q <= rel_t;
			S_IP_RD1: d_q <= {1'b0, tp_q} - {1'b0, t0r_q};
			S_IP_CK1: begin
				div_r_q <= {1'b0, d_q};
				div_q_q <= '0;
				div_d_q <= rel_t - t0r_q;
				cnt_q   <= 6'd16;
			end
			S_FRAC: begin
				if (cnt_q == '0)
					use_frac_q <= 1'b1;
				else begin
					div_r_q <= div_r_n;
					div_q_q <= div_q_n;
					cnt_q   <= cnt_q - 6'd1;
				end
			end
			S_CH_RDB: begin
				a_q   <= vdata;
				smp_q <= vdata;
			end
			S_CH_MUL: prod_q <= ($signed({vdata[31], vdata}) - $signed({a_q[31], a_q}))
				* $signed({1'b0, div_q_q[15:0]});
			S_CH_ADD: smp_q <= a_q + lerp_sum[47:16];
			S_EMIT: if (rsp_free) begin
				rsp_q.status        <= ST_OK;
				rsp_q.current_frame <= fp_q;
				rsp_q.play_time     <= tp_q;
				rsp_q.playing       <= play_q;
				rsp_q.frame_changed <= changed_q;
				rsp_q.out_channel   <= c_q;
				rsp_q.sample_value  <= smp_q;
				rsp_q.last          <= (c_q == CW'(CHANNELS - 1));
				c_q                 <= c_q + CW'(1);
			end
			S_DONE: if (rsp_free) begin
				rsp_q.status        <= status_q;
				rsp_q.current_frame <= fp_q;
				rsp_q.play_time     <= tp_q;
				rsp_q.playing       <= play_q;
				rsp_q.frame_changed <= 1'b0;
				rsp_q.out_channel   <= '0;
				rsp_q.sample_value  <= '0;
				rsp_q.last          <= 1'b1;
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

>>> design/kpi_ram.sv
`default_nettype none
module kpi_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

>>> bench/tb.sv
`default_nettype none
module tb;
	import kpi_pkg::*;

	localparam logic [3:0] OP_UNUSED = 4'd15;
	localparam int LIMIT = 2000000;

	typedef struct {
		bit          is_reg;
		logic [1:0]  idx;
		logic [14:0] wd;
		kpi_req_t    r;
		bit          typed;
		kpi_rsp_t    e;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	kpi_cfg_if cfg_ch();
	kpi_req_if req_ch();
	kpi_rsp_if rsp_ch();

	keyframe_playback_interpolator dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_ch),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Player state as the block should hold it
	logic signed [31:0] ts_mem [MAX_FRAMES];
	logic signed [31:0] smp_mem [MAX_FRAMES*CHANNELS];
	longint fc_r = 0;
	longint spd_r = 256;
	bit loop_r = 1'b1;
	bit interp_r = 1'b1;
	longint ptr_r = 0;
	longint tpos_r = 0;
	bit play_r = 1'b0;
	int nload = 0;

	kpi_rsp_t sample_q [$];
	int snd_idle = 27;
	int rcv_idle = 80;
	int nerr = 0;
	int cyc = 0;

	function automatic longint rel_us(longint i);
		longint d;
		if (i >= MAX_FRAMES)
			return 0;
		d = longint'(ts_mem[i]) - longint'(ts_mem[0]);
		if (d < 0)
			d = 0;
		if (d > 64'sh7FFFFFFF)
			d = 64'sh7FFFFFFF;
		return d;
	endfunction

	function automatic longint span_us();
		return (fc_r != 0) ? rel_us(fc_r - 1) : 0;
	endfunction

	function automatic int smp(longint f, longint c);
		if (f >= MAX_FRAMES)
			return 0;
		return smp_mem[f*CHANNELS + c];
	endfunction

	function automatic void resync();
		longint lo, hi, mid;
		lo = 0;
		hi = fc_r;
		while (lo < hi) begin
			mid = lo + (hi - lo) / 2;
			if (tpos_r < rel_us(mid))
				hi = mid;
			else
				lo = mid + 1;
		end
		ptr_r = (lo != 0) ? lo - 1 : 0;
	endfunction

	function automatic void seek_us(longint tg);
		longint tot;
		tot = span_us();
		if (tg <= 0) begin
			ptr_r = 0;
			tpos_r = 0;
		end else if (tg >= tot) begin
			ptr_r = fc_r - 1;
			tpos_r = tot;
		end else begin
			tpos_r = tg;
			resync();
		end
	endfunction

	function automatic int blend(int a, int b, longint f);
		longint p, q;
		p = (longint'(b) - longint'(a)) * f + 32768;
		q = (p >= 0) ? p / 65536 : -((-p + 65535) / 65536);
		return int'(longint'(a) + q);
	endfunction

	function automatic void post(logic [1:0] st, bit chg, int ch, int s, bit lst);
		kpi_rsp_t o;
		o.status        = st;
		o.current_frame = ptr_r[7:0];
		o.play_time     = tpos_r[30:0];
		o.playing       = play_r;
		o.frame_changed = chg;
		o.out_channel   = ch[3:0];
		o.sample_value  = s;
		o.last          = lst;
		sample_q.push_back(o);
	endfunction

	function automatic void predict(kpi_req_t r);
		longint prv, t, t0, dur, d, frac, tot;
		bit chg;
		bit none;
		int s;
		none = (fc_r == 0);
		case (r.req_type)
			OP_TICK: begin
				if (none) begin
					post(ST_NO_FRAMES, 1'b0, 0, 0, 1'b1);
					return;
				end
				chg = 1'b0;
				frac = -1;
				prv = ptr_r;
				tot = span_us();
				if (play_r && tot > 0) begin
					t = tpos_r + ((longint'(r.dt) * spd_r + 128) >>> 8);
					if (t >= tot) begin
						if (loop_r) begin
							t = t % tot;
						end else begin
							t = tot;
							play_r = 1'b0;
						end
					end
					tpos_r = t;
					resync();
					chg = (ptr_r != prv);
				end
				if (interp_r && ptr_r + 1 < fc_r) begin
					t0 = rel_us(ptr_r);
					dur = rel_us(ptr_r + 1) - t0;
					d = tpos_r - t0;
					if (dur > 0 && d > 0 && d < dur)
						frac = (d * 65536) / dur;
				end
				for (int c = 0; c < CHANNELS; c++) begin
					s = (frac >= 0) ? blend(smp(ptr_r, c), smp(ptr_r + 1, c), frac)
						: smp(ptr_r, c);
					post(ST_OK, chg, c, s, c == CHANNELS - 1);
				end
				return;
			end
			OP_READ: begin
				if (none) begin
					post(ST_NO_FRAMES, 1'b0, 0, 0, 1'b1);
					return;
				end
				for (int c = 0; c < CHANNELS; c++)
					post(ST_OK, 1'b0, c, smp(ptr_r, c), c == CHANNELS - 1);
				return;
			end
			OP_PLAY: begin
				if (none) begin
					post(ST_NO_FRAMES, 1'b0, 0, 0, 1'b1);
					return;
				end
				if (ptr_r >= fc_r - 1) begin
					ptr_r = 0;
					tpos_r = 0;
				end
				play_r = 1'b1;
			end
			OP_PAUSE: begin
				play_r = 1'b0;
			end
			OP_STOP: begin
				play_r = 1'b0;
				ptr_r = 0;
				tpos_r = 0;
			end
			OP_STEP_FWD: begin
				if (none) begin
					post(ST_NO_FRAMES, 1'b0, 0, 0, 1'b1);
					return;
				end
				if (ptr_r + 1 < fc_r) begin
					ptr_r++;
					tpos_r = rel_us(ptr_r);
				end else if (loop_r) begin
					ptr_r = 0;
					tpos_r = 0;
				end else begin
					post(ST_AT_END, 1'b0, 0, 0, 1'b1);
					return;
				end
			end
			OP_STEP_BACK: begin
				if (none) begin
					post(ST_NO_FRAMES, 1'b0, 0, 0, 1'b1);
					return;
				end
				if (ptr_r > 0) begin
					ptr_r--;
					tpos_r = rel_us(ptr_r);
				end else if (loop_r) begin
					ptr_r = fc_r - 1;
					tpos_r = span_us();
				end else begin
					post(ST_AT_END, 1'b0, 0, 0, 1'b1);
					return;
				end
			end
			OP_SEEK_FRAME: begin
				if (none) begin
					post(ST_NO_FRAMES, 1'b0, 0, 0, 1'b1);
					return;
				end
				if (r.frame_index >= fc_r) begin
					post(ST_RANGE, 1'b0, 0, 0, 1'b1);
					return;
				end
				ptr_r = r.frame_index;
				tpos_r = rel_us(r.frame_index);
			end
			OP_SEEK_TIME: begin
				if (none) begin
					post(ST_NO_FRAMES, 1'b0, 0, 0, 1'b1);
					return;
				end
				seek_us(longint'($signed(r.time_arg)));
			end
			OP_SEEK_DELTA: begin
				if (none) begin
					post(ST_NO_FRAMES, 1'b0, 0, 0, 1'b1);
					return;
				end
				seek_us(tpos_r + longint'($signed(r.time_arg)));
			end
			OP_LOAD_TIME: begin
				ts_mem[r.frame_index] = r.time_arg;
			end
			OP_LOAD_VALUE: begin
				smp_mem[r.frame_index*CHANNELS + r.channel] = r.value;
			end
			default: begin
			end
		endcase
		post(ST_OK, 1'b0, 0, 0, 1'b1);
	endfunction

	function automatic void apply_cfg(logic [1:0] idx, logic [14:0] v);
		longint x;
		case (idx)
			REG_FRAME_COUNT: begin
				x = v[8:0];
				fc_r = (x > MAX_FRAMES) ? MAX_FRAMES : x;
				if (fc_r == 0)
					ptr_r = 0;
				else if (ptr_r >= fc_r)
					ptr_r = fc_r - 1;
			end
			REG_SPEED: begin
				x = v;
				if (x < 3)
					x = 3;
				if (x > 25600)
					x = 25600;
				spd_r = x;
			end
			REG_LOOP: loop_r = v[0];
			REG_INTERP: interp_r = v[0];
			default: begin
			end
		endcase
	endfunction

	function automatic kpi_rsp_t one(logic [1:0] st);
		kpi_rsp_t o;
		o = '0;
		o.status = st;
		o.last = 1'b1;
		return o;
	endfunction

	function automatic plan_row_t rq(logic [3:0] op, logic [15:0] dt, logic [7:0] fi,
			logic signed [31:0] ta, bit typed = 1'b0, logic [1:0] st = ST_OK);
		plan_row_t p;
		p.is_reg = 1'b0;
		p.idx = '0;
		p.wd = '0;
		p.r = '0;
		p.r.req_type = op;
		p.r.dt = dt;
		p.r.frame_index = fi;
		p.r.time_arg = ta;
		p.typed = typed;
		p.e = one(st);
		return p;
	endfunction

	function automatic plan_row_t rg(logic [1:0] idx, logic [14:0] wd);
		plan_row_t p;
		p = rq(OP_UNUSED, '0, '0, '0);
		p.is_reg = 1'b1;
		p.idx = idx;
		p.wd = wd;
		return p;
	endfunction

	function automatic logic signed [31:0] rand_sample();
		case ($urandom_range(5))
			0: return 32'sh80000000;
			1: return 32'sh7FFFFFFF;
			default: return $urandom;
		endcase
	endfunction

	function automatic kpi_req_t pick();
		kpi_req_t r;
		int w;
		int tot;
		r.dt = $urandom;
		r.frame_index = $urandom;
		r.channel = $urandom;
		r.value = rand_sample();
		r.time_arg = $urandom;
		w = $urandom_range(99);
		tot = int'(span_us());
		if (w < 30) begin
			r.req_type = OP_TICK;
			case ($urandom_range(9))
				0: r.dt = 16'd0;
				1: r.dt = 16'hFFFF;
				2, 3: r.dt = $urandom;
				default: r.dt = $urandom_range(0, 3000);
			endcase
		end else if (w < 38) r.req_type = OP_PLAY;
		else if (w < 41) r.req_type = OP_PAUSE;
		else if (w < 43) r.req_type = OP_STOP;
		else if (w < 50) r.req_type = OP_STEP_FWD;
		else if (w < 57) r.req_type = OP_STEP_BACK;
		else if (w < 64) begin
			r.req_type = OP_SEEK_FRAME;
			if ($urandom_range(4) != 0)
				r.frame_index = $urandom_range(0, (fc_r < 255) ? int'(fc_r) : 255);
		end else if (w < 72) begin
			r.req_type = OP_SEEK_TIME;
			if ($urandom_range(3) != 0)
				r.time_arg = $urandom_range(0, (tot < 1000000) ? tot + 4000 : 2000000) - 2000;
		end else if (w < 80) begin
			r.req_type = OP_SEEK_DELTA;
			if ($urandom_range(3) != 0)
				r.time_arg = $urandom_range(0, 10000) - 5000;
		end else if (w < 85) begin
			r.req_type = OP_LOAD_TIME;
			if (fc_r < MAX_FRAMES && $urandom_range(4) != 0) begin
				r.frame_index = $urandom_range(int'(fc_r), MAX_FRAMES - 1);
			end else if (fc_r != 0) begin
				r.frame_index = $urandom_range(0, int'(fc_r) - 1);
				r.time_arg = ts_mem[r.frame_index] + $urandom_range(0, 100) - 50;
			end
		end else if (w < 90) r.req_type = OP_LOAD_VALUE;
		else if (w < 97) r.req_type = OP_READ;
		else r.req_type = $urandom_range(12, 15);
		if (fc_r > nload && (r.req_type == OP_LOAD_TIME || r.req_type == OP_LOAD_VALUE))
			r.req_type = OP_PAUSE;
		return r;
	endfunction

	task automatic send(kpi_req_t r, bit typed = 1'b0, kpi_rsp_t e = '0);
		req_ch.valid <= 1'b1;
		req_ch.data <= r;
		do @(posedge clk); while (!req_ch.ready);
		predict(r);
		if (typed)
			sample_q[sample_q.size() - 1] = e;
		if ($urandom_range(99) < snd_idle) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic settle();
		req_ch.valid <= 1'b0;
		while (sample_q.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic wr_reg(logic [1:0] idx, logic [14:0] wd);
		settle();
		cfg_ch.valid <= 1'b1;
		cfg_ch.wr_index <= idx;
		cfg_ch.wr_data <= wd;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		apply_cfg(idx, wd);
	endtask

	task automatic load_frame(int i, logic signed [31:0] t);
		kpi_req_t r;
		r = '0;
		r.req_type = OP_LOAD_TIME;
		r.frame_index = i;
		r.time_arg = t;
		send(r);
		r.req_type = OP_LOAD_VALUE;
		for (int c = 0; c < CHANNELS; c++) begin
			r.channel = c;
			r.value = rand_sample();
			send(r);
		end
		if (i == nload)
			nload = i + 1;
	endtask

	task automatic load_span(int first, int cnt, longint t, int maxstep);
		for (int i = first; i < first + cnt; i++) begin
			load_frame(i, t);
			t += $urandom_range(0, maxstep);
		end
	endtask

	task automatic load_ts(int i, logic signed [31:0] t);
		kpi_req_t r;
		r = '0;
		r.req_type = OP_LOAD_TIME;
		r.frame_index = i;
		r.time_arg = t;
		send(r);
	endtask

	task automatic run_random(int n);
		for (int k = 0; k < n; k++) begin
			if (k == n / 2)
				settle();
			send(pick());
		end
	endtask

	always @(posedge clk) begin
		kpi_rsp_t e;
		cyc++;
		if (cyc > LIMIT) begin
			$display("keyframe_playback_interpolator: mismatch");
			$finish;
		end
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (sample_q.size() == 0) begin
				nerr++;
				if (nerr <= 10)
					$display("unexpected transaction: %p", rsp_ch.data);
			end else begin
				e = sample_q.pop_front();
				if (rsp_ch.data !== e) begin
					nerr++;
					if (nerr <= 10)
						$display("expected %p, got %p", e, rsp_ch.data);
				end
			end
		end
		rsp_ch.ready <= ($urandom_range(99) >= rcv_idle);
	end

	initial begin
		plan_row_t plan [$];
		logic signed [31:0] ts0, ts1;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.wr_index = '0;
		cfg_ch.wr_data = '0;
		rsp_ch.ready = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		load_span(0, 8, longint'($urandom_range(0, 200000)) - 100000, 4000);

		plan.push_back(rq(OP_TICK, 16'd100, 8'd0, 0, 1, ST_NO_FRAMES));
		plan.push_back(rq(OP_PLAY, 0, 0, 0, 1, ST_NO_FRAMES));
		plan.push_back(rq(OP_STEP_FWD, 0, 0, 0, 1, ST_NO_FRAMES));
		plan.push_back(rq(OP_STEP_BACK, 0, 0, 0, 1, ST_NO_FRAMES));
		plan.push_back(rq(OP_SEEK_FRAME, 0, 8'd0, 0, 1, ST_NO_FRAMES));
		plan.push_back(rq(OP_SEEK_TIME, 0, 0, 32'sd1000, 1, ST_NO_FRAMES));
		plan.push_back(rq(OP_SEEK_DELTA, 0, 0, -32'sd5, 1, ST_NO_FRAMES));
		plan.push_back(rq(OP_READ, 0, 0, 0, 1, ST_NO_FRAMES));
		plan.push_back(rq(OP_PAUSE, 0, 0, 0, 1, ST_OK));
		plan.push_back(rq(OP_UNUSED, 0, 0, 0, 1, ST_OK));
		plan.push_back(rg(REG_FRAME_COUNT, 15'd8));
		plan.push_back(rq(OP_STOP, 0, 0, 0, 1, ST_OK));
		plan.push_back(rq(OP_SEEK_FRAME, 0, 8'd255, 0, 1, ST_RANGE));
		plan.push_back(rq(OP_SEEK_FRAME, 0, 8'd8, 0, 1, ST_RANGE));
		plan.push_back(rq(OP_READ, 0, 0, 0));
		plan.push_back(rq(OP_PLAY, 0, 0, 0));
		plan.push_back(rq(OP_TICK, 16'd0, 0, 0));
		plan.push_back(rq(OP_TICK, 16'd1500, 0, 0));
		plan.push_back(rq(OP_TICK, 16'hFFFF, 0, 0));
		plan.push_back(rq(OP_SEEK_TIME, 0, 0, 32'sh80000000));
		plan.push_back(rq(OP_SEEK_TIME, 0, 0, 32'sh7FFFFFFF));
		plan.push_back(rq(OP_SEEK_DELTA, 0, 0, -32'sd1));
		plan.push_back(rq(OP_STEP_FWD, 0, 0, 0));
		plan.push_back(rg(REG_LOOP, 15'd0));
		plan.push_back(rg(REG_INTERP, 15'd0));
		plan.push_back(rg(REG_SPEED, 15'd25600));
		plan.push_back(rq(OP_STOP, 0, 0, 0, 1, ST_OK));
		plan.push_back(rq(OP_STEP_BACK, 0, 0, 0, 1, ST_AT_END));
		plan.push_back(rq(OP_SEEK_FRAME, 0, 8'd7, 0));
		plan.push_back(rq(OP_STEP_FWD, 0, 0, 0));
		plan.push_back(rq(OP_PLAY, 0, 0, 0));
		plan.push_back(rq(OP_TICK, 16'hFFFF, 0, 0));
		plan.push_back(rq(OP_TICK, 16'd100, 0, 0));
		plan.push_back(rg(REG_SPEED, 15'd0));
		plan.push_back(rg(REG_LOOP, 15'd1));
		plan.push_back(rg(REG_INTERP, 15'd1));

		foreach (plan[i]) begin
			if (plan[i].is_reg)
				wr_reg(plan[i].idx, plan[i].wd);
			else
				send(plan[i].r, plan[i].typed, plan[i].e);
		end

		wr_reg(REG_SPEED, 15'd256);
		run_random(150);

		settle();
		snd_idle = 80;
		rcv_idle = 27;
		ts0 = ts_mem[0];
		ts1 = ts_mem[1];
		load_ts(0, 32'sh80000000);
		load_ts(1, 32'sh7FFFFFFF);
		wr_reg(REG_FRAME_COUNT, 15'd2);
		wr_reg(REG_SPEED, $urandom_range(0, 32767));
		wr_reg(REG_LOOP, $urandom_range(1));
		run_random(130);
		wr_reg(REG_FRAME_COUNT, 15'd1);
		run_random(20);
		wr_reg(REG_FRAME_COUNT, 15'd0);
		load_ts(0, ts0);
		load_ts(1, ts1);

		settle();
		snd_idle = 0;
		rcv_idle = 0;
		wr_reg(REG_FRAME_COUNT, $urandom_range(3, 8));
		wr_reg(REG_LOOP, $urandom_range(1));
		wr_reg(REG_INTERP, $urandom_range(1));
		wr_reg(REG_SPEED, $urandom_range(64, 2048));
		run_random(160);

		wr_reg(REG_FRAME_COUNT, 15'd0);
		load_span(8, MAX_FRAMES - 8, longint'(ts_mem[7]) + 100, 3000);
		wr_reg(REG_FRAME_COUNT, 15'd511);
		wr_reg(REG_LOOP, 15'd1);
		send(rq(OP_SEEK_FRAME, 0, 8'd255, 0).r);
		run_random(30);
		wr_reg(REG_FRAME_COUNT, 15'd0);
		run_random(5);

		settle();
		if (sample_q.size() != 0)
			nerr++;
		if (nerr == 0)
			$display("keyframe_playback_interpolator: match");
		else
			$display("keyframe_playback_interpolator: mismatch");
		$finish;
	end

endmodule
`default_nettype wire
